[hw/rtl/touch_strip_position_tracker_defines.svh]
// Assertion macros for the touch strip position tracker.
`ifndef TOUCH_STRIP_POSITION_TRACKER_DEFINES_SVH
`define TOUCH_STRIP_POSITION_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that cond holds at every clock edge outside reset.
`define TSPT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Check that cons holds whenever ante holds.
`define TSPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Check that cons holds in the cycle after ante.
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TSPT_ASSERT_ALWAYS(lbl, cond, msg)
`define TSPT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TSPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/tspt_pkg.sv]
// Types and constants shared by the touch strip position tracker files.
package tspt_pkg;

   localparam int IDX_W   = 5;
   localparam int POS_W   = 7;
   localparam int STATE_W = 2;

   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic [STATE_W-1:0]        state_code_type;

   typedef enum logic [STATE_W-1:0] {
      MODE_EMPTY  = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_DOUBLE = 2'd2
   } mode_type;

   localparam logic OP_TOUCH   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Position reported when no electrode is held.
   localparam pos_type POS_NONE = {POS_W{1'b1}};

   typedef struct packed {
      pos_type        position;
      state_code_type touch_state;
   } result_type;

endpackage

[hw/rtl/tspt_req_intf.sv]
// Request channel: touch or release events.
interface tspt_req_intf;
   logic              valid;
   logic              ready;
   logic              opcode;
   tspt_pkg::idx_type electrode;

   modport source (output valid, output opcode, output electrode, input ready);
   modport sink   (input valid, input opcode, input electrode, output ready);
endinterface

[hw/rtl/tspt_rsp_intf.sv]
// Result channel: tracking state and position.
interface tspt_rsp_intf;
   logic                     valid;
   logic                     ready;
   tspt_pkg::pos_type        position;
   tspt_pkg::state_code_type touch_state;

   modport source (output valid, output position, output touch_state, input ready);
   modport sink   (input valid, input position, input touch_state, output ready);
endinterface

[hw/rtl/touch_strip_position_tracker.sv]
// Touch strip position tracker: event decode, tracking state and result buffer.
// One request (touch or release of one electrode) yields one result: the
// tracking state after the event and the position in half-electrode steps
// (twice the index for a single touch, the sum of both held indices for a double
// touch, -1 when nothing is held). The tracking state updates in the cycle a
// request is taken and its result goes into the result buffer, so one request
// per clock is accepted. A two-entry result buffer sets the stall behavior:
// requests keep flowing until two results wait unread. Events on electrodes at
// or above ELECTRODES leave the state unchanged and report it as it stands.
`include "touch_strip_position_tracker_defines.svh"

module touch_strip_position_tracker #(
   parameter int ELECTRODES = 32
) (
   input  logic           clock,
   input  logic           reset,
   tspt_req_intf.sink     req_bus,
   tspt_rsp_intf.source   rsp_bus
);

   // Tracking state
   tspt_pkg::mode_type mode_ff, mode_in;
   tspt_pkg::idx_type  newest_ff, newest_in;
   tspt_pkg::idx_type  older_ff, older_in;

   // Result buffer: entry 0 is the head
   tspt_pkg::result_type slot_ff [2];
   tspt_pkg::result_type slot_in [2];
   logic [1:0]           count_ff, count_in;

   logic                 push, pop;
   logic                 on_strip;
   logic [tspt_pkg::IDX_W:0] e_x, n_x, lo_x, hi_x;
   tspt_pkg::result_type new_result;

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign on_strip      = (32'(req_bus.electrode) < 32'(ELECTRODES));

   // Widen indices by one bit so neighbor compares do not wrap
   assign e_x  = {1'b0, req_bus.electrode};
   assign n_x  = {1'b0, newest_ff};
   assign lo_x = (newest_ff < older_ff) ? {1'b0, newest_ff} : {1'b0, older_ff};
   assign hi_x = (newest_ff < older_ff) ? {1'b0, older_ff}  : {1'b0, newest_ff};

   // Next tracking state for the incoming event
   always_comb begin
      mode_in   = mode_ff;
      newest_in = newest_ff;
      older_in  = older_ff;
      if (push && on_strip) begin
         if (req_bus.opcode == tspt_pkg::OP_TOUCH) begin
            case (mode_ff)
               tspt_pkg::MODE_EMPTY: begin
                  newest_in = req_bus.electrode;
                  mode_in   = tspt_pkg::MODE_SINGLE;
               end
               tspt_pkg::MODE_SINGLE: begin
                  newest_in = req_bus.electrode;
                  if ((e_x + 1'b1 == n_x) || (e_x == n_x + 1'b1)) begin
                     older_in = newest_ff;
                     mode_in  = tspt_pkg::MODE_DOUBLE;
                  end
               end
               tspt_pkg::MODE_DOUBLE: begin
                  newest_in = req_bus.electrode;
                  if ((e_x + 1'b1 == lo_x) || (e_x == hi_x + 1'b1)) begin
                     older_in = newest_ff;
                  end else begin
                     mode_in = tspt_pkg::MODE_SINGLE;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end else begin
            case (mode_ff)
               tspt_pkg::MODE_SINGLE: begin
                  if (req_bus.electrode == newest_ff) begin
                     mode_in = tspt_pkg::MODE_EMPTY;
                  end
               end
               tspt_pkg::MODE_DOUBLE: begin
                  if (req_bus.electrode == older_ff) begin
                     mode_in = tspt_pkg::MODE_SINGLE;
                  end else if (req_bus.electrode == newest_ff) begin
                     newest_in = older_ff;
                     mode_in   = tspt_pkg::MODE_SINGLE;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   // Form the result from the updated state
   always_comb begin
      new_result.touch_state = tspt_pkg::state_code_type'(mode_in);
      case (mode_in)
         tspt_pkg::MODE_SINGLE: begin
            new_result.position = tspt_pkg::pos_type'({1'b0, newest_in, 1'b0});
         end
         tspt_pkg::MODE_DOUBLE: begin
            new_result.position = tspt_pkg::pos_type'(newest_in) +
                                  tspt_pkg::pos_type'(older_in);
         end
         default: begin
            new_result.position = tspt_pkg::POS_NONE;
         end
      endcase
   end

   // Advance the result buffer
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot_in[0] = new_result;
            end else begin
               slot_in[1] = new_result;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot_in[0] = slot_ff[1];
            count_in   = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot_in[0] = new_result;
            end else begin
               slot_in[0] = slot_ff[1];
               slot_in[1] = new_result;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tspt_pkg::MODE_EMPTY;
         count_ff <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      newest_ff  <= newest_in;
      older_ff   <= older_in;
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_bus.valid       = (count_ff != 2'd0);
   assign rsp_bus.position    = slot_ff[0].position;
   assign rsp_bus.touch_state = slot_ff[0].touch_state;

   // Checks
   `TSPT_ASSERT_ALWAYS(a_count_range, count_ff != 2'd3, "result buffer overfilled")
   `TSPT_ASSERT_IMPLY(a_pair_distinct, mode_ff == tspt_pkg::MODE_DOUBLE,
      newest_ff != older_ff, "held pair repeats an index")
   `TSPT_ASSERT_NEXT(a_push_fills, push && !pop, count_ff == $past(count_ff) + 2'd1,
      "accepted request not buffered")
   `TSPT_ASSERT_IMPLY(a_empty_pos,
      rsp_bus.valid && rsp_bus.touch_state == tspt_pkg::state_code_type'(tspt_pkg::MODE_EMPTY),
      rsp_bus.position == tspt_pkg::POS_NONE, "empty result with a position")

endmodule

[test/touch_strip_position_tracker_tb.sv]
// Testbench for the touch strip position tracker: directed table, random events, self-check.
`timescale 1ns / 100ps

module touch_strip_position_tracker_tb;

   localparam int ELECTRODES   = 32;
   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_TAIL   = 150;
   localparam int DIR_ROWS     = 25;

   // One directed request; the fixed expectation is used only where fixed_exp is set
   typedef struct packed {
      logic                     op;
      tspt_pkg::idx_type        e;
      logic                     fixed_exp;
      tspt_pkg::pos_type        pos;
      tspt_pkg::state_code_type st;
   } dir_row_type;

   logic clock;
   logic reset;

   tspt_req_intf req_bus ();
   tspt_rsp_intf rsp_bus ();

   touch_strip_position_tracker #(
      .ELECTRODES(ELECTRODES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Tracking state mirrored on the checker side
   tspt_pkg::mode_type trk_mode;
   int                 trk_newest;
   int                 trk_older;

   tspt_pkg::result_type pending_results[$];
   int                   error_count;
   int                   touch_count;
   int                   release_count;
   int                   double_count;
   int                   empty_count;
   bit                   idle_on;

   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{tspt_pkg::OP_RELEASE, 5'd5,  1'b1, tspt_pkg::POS_NONE, tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd31, 1'b1, 7'sd62,             tspt_pkg::MODE_SINGLE},
      '{tspt_pkg::OP_TOUCH,   5'd30, 1'b1, 7'sd61,             tspt_pkg::MODE_DOUBLE},
      '{tspt_pkg::OP_TOUCH,   5'd31, 1'b1, 7'sd62,             tspt_pkg::MODE_SINGLE},
      '{tspt_pkg::OP_RELEASE, 5'd31, 1'b1, tspt_pkg::POS_NONE, tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd0,  1'b1, 7'sd0,              tspt_pkg::MODE_SINGLE},
      '{tspt_pkg::OP_TOUCH,   5'd1,  1'b1, 7'sd1,              tspt_pkg::MODE_DOUBLE},
      '{tspt_pkg::OP_TOUCH,   5'd2,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd0,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd2,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd0,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd7,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd1,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd1,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd0,  1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd15, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd16, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd20, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd19, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd21, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd21, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_TOUCH,   5'd18, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd19, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd18, 1'b0, 7'sd0,              tspt_pkg::MODE_EMPTY},
      '{tspt_pkg::OP_RELEASE, 5'd18, 1'b1, tspt_pkg::POS_NONE, tspt_pkg::MODE_EMPTY}
   };

   // Apply one event to the mirrored state and return the expected state and position
   function automatic tspt_pkg::result_type track_event(input logic op,
                                                        input tspt_pkg::idx_type e);
      int                   ei;
      int                   lo;
      int                   hi;
      tspt_pkg::result_type r;
      ei = int'(e);
      if (ei < ELECTRODES) begin
         if (op == tspt_pkg::OP_TOUCH) begin
            case (trk_mode)
               tspt_pkg::MODE_EMPTY: begin
                  trk_newest = ei;
                  trk_mode   = tspt_pkg::MODE_SINGLE;
               end
               tspt_pkg::MODE_SINGLE: begin
                  if (ei == trk_newest - 1 || ei == trk_newest + 1) begin
                     trk_older  = trk_newest;
                     trk_newest = ei;
                     trk_mode   = tspt_pkg::MODE_DOUBLE;
                  end else begin
                     trk_newest = ei;
                  end
               end
               default: begin
                  lo = (trk_newest < trk_older) ? trk_newest : trk_older;
                  hi = (trk_newest < trk_older) ? trk_older : trk_newest;
                  if (ei == lo - 1 || ei == hi + 1) begin
                     trk_older  = trk_newest;
                     trk_newest = ei;
                  end else begin
                     trk_newest = ei;
                     trk_older  = -1;
                     trk_mode   = tspt_pkg::MODE_SINGLE;
                  end
               end
            endcase
         end else begin
            if (ei == trk_older) begin
               trk_older = -1;
               trk_mode  = tspt_pkg::MODE_SINGLE;
            end else if (ei == trk_newest) begin
               trk_newest = trk_older;
               trk_older  = -1;
               trk_mode   = tspt_pkg::MODE_SINGLE;
            end
            if (trk_older == -1 && trk_newest == -1) begin
               trk_mode = tspt_pkg::MODE_EMPTY;
            end
         end
      end
      case (trk_mode)
         tspt_pkg::MODE_SINGLE: r.position = tspt_pkg::pos_type'(trk_newest * 2);
         tspt_pkg::MODE_DOUBLE: r.position = tspt_pkg::pos_type'(trk_newest + trk_older);
         default:               r.position = tspt_pkg::POS_NONE;
      endcase
      r.touch_state = trk_mode;
      return r;
   endfunction

   // Pick the next random event, biased toward sliding pairs and real releases
   task automatic pick_event(output logic op, output tspt_pkg::idx_type e);
      int roll;
      int lo;
      int hi;
      int cand;
      roll = $urandom_range(0, 99);
      op   = tspt_pkg::OP_TOUCH;
      e    = tspt_pkg::idx_type'($urandom_range(0, ELECTRODES - 1));
      if (roll < 10) begin
         op = logic'($urandom_range(0, 1));
      end else begin
         case (trk_mode)
            tspt_pkg::MODE_EMPTY: begin
               if (roll < 20) op = tspt_pkg::OP_RELEASE;
            end
            tspt_pkg::MODE_SINGLE: begin
               if (roll < 50) begin
                  cand = $urandom_range(0, 1) ? trk_newest + 1 : trk_newest - 1;
                  if (cand < 0) cand = trk_newest + 1;
                  if (cand >= ELECTRODES) cand = trk_newest - 1;
                  e = tspt_pkg::idx_type'(cand);
               end else if (roll < 65) begin
                  op = tspt_pkg::OP_RELEASE;
                  e  = tspt_pkg::idx_type'(trk_newest);
               end else if (roll < 72) begin
                  e = tspt_pkg::idx_type'(trk_newest);
               end else if (roll < 80) begin
                  op = tspt_pkg::OP_RELEASE;
               end
            end
            default: begin
               lo = (trk_newest < trk_older) ? trk_newest : trk_older;
               hi = (trk_newest < trk_older) ? trk_older : trk_newest;
               if (roll < 55) begin
                  cand = $urandom_range(0, 1) ? hi + 1 : lo - 1;
                  if (cand < 0) cand = hi + 1;
                  if (cand >= ELECTRODES) cand = lo - 1;
                  e = tspt_pkg::idx_type'(cand);
               end else if (roll < 75) begin
                  op = tspt_pkg::OP_RELEASE;
                  e  = tspt_pkg::idx_type'($urandom_range(0, 1) ? trk_newest : trk_older);
               end else if (roll < 82) begin
                  e = tspt_pkg::idx_type'($urandom_range(0, 1) ? trk_newest : trk_older);
               end else if (roll < 90) begin
                  op = tspt_pkg::OP_RELEASE;
               end
            end
         endcase
      end
   endtask

   // Drive one request, hold until accepted, return the predicted result
   task automatic send_event(input logic op, input tspt_pkg::idx_type e,
                             output tspt_pkg::result_type predicted);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.electrode <= e;
      do @(posedge clock); while (!req_bus.ready);
      predicted = track_event(op, e);
      if (op == tspt_pkg::OP_TOUCH) touch_count++;
      else release_count++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Time limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random stall bursts, none in the quiet tail
   initial begin
      forever begin
         if (!idle_on) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat (($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12)) @(posedge clock);
            if ($urandom_range(0, 1) == 1) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      tspt_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: position %0d, touch_state %0d",
                   rsp_bus.position, rsp_bus.touch_state);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.position !== want.position) begin
               $error("position mismatch: expected %0d, actual %0d",
                      want.position, rsp_bus.position);
               error_count++;
            end
            if (rsp_bus.touch_state !== want.touch_state) begin
               $error("touch_state mismatch: expected %0d, actual %0d",
                      want.touch_state, rsp_bus.touch_state);
               error_count++;
            end
            if (want.touch_state == tspt_pkg::MODE_DOUBLE) double_count++;
            if (want.touch_state == tspt_pkg::MODE_EMPTY) empty_count++;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic                 op;
      tspt_pkg::idx_type    e;
      tspt_pkg::result_type predicted;
      int                   waited;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = tspt_pkg::OP_TOUCH;
      req_bus.electrode = '0;
      trk_mode          = tspt_pkg::MODE_EMPTY;
      trk_newest        = -1;
      trk_older         = -1;
      error_count       = 0;
      touch_count       = 0;
      release_count     = 0;
      double_count      = 0;
      empty_count       = 0;
      idle_on           = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: fixed expectations where given, predictor otherwise
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_event(dir_rows[i].op, dir_rows[i].e, predicted);
         if (dir_rows[i].fixed_exp) begin
            predicted.position    = dir_rows[i].pos;
            predicted.touch_state = dir_rows[i].st;
         end
         pending_results.push_back(predicted);
      end

      // Hold the sender until every directed result is back
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      // Random events
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (i == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
         pick_event(op, e);
         send_event(op, e, predicted);
         pending_results.push_back(predicted);
      end
      req_bus.valid <= 1'b0;

      // Drain
      waited = 0;
      while (pending_results.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);

      $display("Covered %0d touches and %0d releases; %0d results in double touch, %0d empty.",
               touch_count, release_count, double_count, empty_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
         end
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tspt_pkg.sv
hw/rtl/tspt_req_intf.sv
hw/rtl/tspt_rsp_intf.sv
hw/rtl/touch_strip_position_tracker.sv
test/touch_strip_position_tracker_tb.sv
